/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every rising edge outside reset.
`define SFT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Implication checked from one edge to the next.
`define SFT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");

`else

`define SFT_ASSERT(label, clk, rst_n, prop)
`define SFT_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

/* rtl/sft_pkg.sv */
package sft_pkg;

	localparam int unsigned PULSE_W = 12;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned COL_W   = 10;
	localparam int unsigned CFG_AW  = 3;
	localparam int unsigned CFG_DW  = 16;

	localparam logic [PULSE_W-1:0] PULSE_MIN    = 12'd500;
	localparam logic [PULSE_W-1:0] PULSE_MAX    = 12'd2500;
	localparam logic [PULSE_W-1:0] PULSE_CENTRE = 12'd1500;
	localparam logic [PULSE_W-1:0] SWEEP_LOW    = 12'd550;
	localparam logic [PULSE_W-1:0] SWEEP_HIGH   = 12'd2450;

	// mag / 24 = (mag >> 3) / 3, the divide by 3 as multiply by 171 and shift by 9
	localparam logic [7:0] RECIP3     = 8'd171;
	localparam int unsigned RECIP3_SH = 9;

	typedef enum logic [2:0] {
		ACT_RATE_SKIP  = 3'd0,
		ACT_LOST_START = 3'd1,
		ACT_LOST_WAIT  = 3'd2,
		ACT_SCAN_WAIT  = 3'd3,
		ACT_SCAN_MOVE  = 3'd4,
		ACT_DEAD_ZONE  = 3'd5,
		ACT_TRACKED    = 3'd6
	} action_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_CENTER_X     = 3'd0,
		REG_DEAD_ZONE    = 3'd1,
		REG_BASE_STEP    = 3'd2,
		REG_MAX_STEP     = 3'd3,
		REG_TRACK_PERIOD = 3'd4,
		REG_LOST_DELAY   = 3'd5,
		REG_SCAN_PERIOD  = 3'd6,
		REG_SCAN_STEP    = 3'd7
	} reg_idx_t;

endpackage

/* rtl/servo_face_track_scan.sv */
// Face-tracking pan servo controller. Each input transaction carries a millisecond
// timestamp (s_tdata[31:0]), the face column (s_tdata[41:32]) and a face-present flag
// (s_tuser); each one yields exactly one output transaction with the new servo pulse
// in microseconds (m_tdata[11:0]) and the action code (m_tuser). The block takes one
// transaction per clock while the sink keeps m_tready high: the input register
// feeds combinational decision logic that updates the servo state and loads the
// output register. Configuration is to be written by the user through
// cfg_we/cfg_addr/cfg_wdata only while no transaction is in flight; the block
// itself does not enforce this.
`include "assert_macros.svh"

module servo_face_track_scan (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // now_ms[31:0], face_col[41:32], zero fill
	input  logic        s_tuser,   // face_found
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // pulse_width[11:0], zero fill
	output logic [2:0]  m_tuser,   // action
	input  logic        cfg_we,
	input  logic [sft_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [sft_pkg::CFG_DW-1:0] cfg_wdata
);

	// configuration
	logic [9:0]  center_x_q;
	logic [7:0]  dead_zone_q;
	logic [7:0]  base_step_q;
	logic [10:0] max_step_q;
	logic [15:0] track_period_q;
	logic [15:0] lost_delay_q;
	logic [15:0] scan_period_q;
	logic [7:0]  scan_step_q;

	// servo state
	logic [sft_pkg::PULSE_W-1:0] pulse_q;
	logic [sft_pkg::TIME_W-1:0]  last_track_q;
	logic [sft_pkg::TIME_W-1:0]  last_scan_q;
	logic [sft_pkg::TIME_W-1:0]  lost_q;
	logic                        sweep_up_q;

	// input stage
	logic                        valid_s1;
	logic [sft_pkg::TIME_W-1:0]  now_s1;
	logic                        found_s1;
	logic [sft_pkg::COL_W-1:0]   col_s1;

	// output stage
	logic                        out_valid_q;
	logic [sft_pkg::PULSE_W-1:0] out_pulse_q;
	sft_pkg::action_t            out_action_q;

	logic advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q     <= 10'd120;
			dead_zone_q    <= 8'd16;
			base_step_q    <= 8'd20;
			max_step_q     <= 11'd90;
			track_period_q <= 16'd20;
			lost_delay_q   <= 16'd800;
			scan_period_q  <= 16'd60;
			scan_step_q    <= 8'd32;
		end else if (cfg_we) begin
			unique case (sft_pkg::reg_idx_t'(cfg_addr))
				sft_pkg::REG_CENTER_X:     center_x_q     <= cfg_wdata[9:0];
				sft_pkg::REG_DEAD_ZONE:    dead_zone_q    <= cfg_wdata[7:0];
				sft_pkg::REG_BASE_STEP:    base_step_q    <= cfg_wdata[7:0];
				sft_pkg::REG_MAX_STEP:     max_step_q     <= cfg_wdata[10:0];
				sft_pkg::REG_TRACK_PERIOD: track_period_q <= cfg_wdata;
				sft_pkg::REG_LOST_DELAY:   lost_delay_q   <= cfg_wdata;
				sft_pkg::REG_SCAN_PERIOD:  scan_period_q  <= cfg_wdata;
				sft_pkg::REG_SCAN_STEP:    scan_step_q    <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// decision logic
	logic [sft_pkg::TIME_W-1:0]   track_el;
	logic [sft_pkg::TIME_W-1:0]   lost_el;
	logic [sft_pkg::TIME_W-1:0]   scan_el;
	logic signed [10:0]           err;
	logic [9:0]                   mag;
	logic [14:0]                  recip_prod;
	logic [5:0]                   band;
	logic [13:0]                  step_raw;
	logic [10:0]                  step_cap;
	logic signed [13:0]           pulse_ext;
	logic signed [13:0]           track_up;
	logic signed [13:0]           track_dn;
	logic signed [13:0]           scan_up;
	logic signed [13:0]           scan_dn;
	logic signed [13:0]           nxt;
	logic                         move;
	sft_pkg::action_t             act;
	logic [sft_pkg::PULSE_W-1:0]  pulse_n;
	logic [sft_pkg::TIME_W-1:0]   last_track_n;
	logic [sft_pkg::TIME_W-1:0]   last_scan_n;
	logic [sft_pkg::TIME_W-1:0]   lost_n;
	logic                         sweep_up_n;

	always_comb begin
		track_el = now_s1 - last_track_q;
		lost_el  = now_s1 - lost_q;
		scan_el  = now_s1 - last_scan_q;

		err = signed'({1'b0, col_s1}) - signed'({1'b0, center_x_q});
		mag = err[10] ? 10'(-err) : err[9:0];

		recip_prod = 15'({8'd0, mag[9:3]} * {7'd0, sft_pkg::RECIP3});
		band       = recip_prod[14:sft_pkg::RECIP3_SH] + 6'd1;
		step_raw   = 14'({8'd0, band} * {6'd0, base_step_q});
		step_cap   = (step_raw > {3'd0, max_step_q}) ? max_step_q : step_raw[10:0];

		pulse_ext = signed'({2'b00, pulse_q});
		track_up  = pulse_ext + signed'({3'b000, step_cap});
		track_dn  = pulse_ext - signed'({3'b000, step_cap});
		scan_up   = pulse_ext + signed'({6'd0, scan_step_q});
		scan_dn   = pulse_ext - signed'({6'd0, scan_step_q});

		act          = sft_pkg::ACT_RATE_SKIP;
		move         = 1'b0;
		nxt          = pulse_ext;
		last_track_n = last_track_q;
		last_scan_n  = last_scan_q;
		lost_n       = lost_q;
		sweep_up_n   = sweep_up_q;

		priority if (track_el < {16'd0, track_period_q}) begin
			act = sft_pkg::ACT_RATE_SKIP;
		end else if (!found_s1) begin
			last_track_n = now_s1;
			priority if (lost_q == '0) begin
				lost_n = now_s1;
				act    = sft_pkg::ACT_LOST_START;
			end else if (lost_el < {16'd0, lost_delay_q}) begin
				act = sft_pkg::ACT_LOST_WAIT;
			end else if (scan_el < {16'd0, scan_period_q}) begin
				act = sft_pkg::ACT_SCAN_WAIT;
			end else begin
				last_scan_n = now_s1;
				act         = sft_pkg::ACT_SCAN_MOVE;
				move        = 1'b1;
				// turn at the sweep limits, same step in the new direction
				if (sweep_up_q) begin
					if (pulse_q >= sft_pkg::SWEEP_HIGH) begin
						sweep_up_n = 1'b0;
						nxt        = scan_dn;
					end else begin
						nxt = scan_up;
					end
				end else begin
					if (pulse_q <= sft_pkg::SWEEP_LOW) begin
						sweep_up_n = 1'b1;
						nxt        = scan_up;
					end else begin
						nxt = scan_dn;
					end
				end
			end
		end else begin
			last_track_n = now_s1;
			lost_n       = '0;
			if (mag <= {2'b00, dead_zone_q}) begin
				act = sft_pkg::ACT_DEAD_ZONE;
			end else begin
				act  = sft_pkg::ACT_TRACKED;
				move = 1'b1;
				// inverted steering: face left of centre raises the pulse
				nxt  = err[10] ? track_up : track_dn;
			end
		end

		priority if (!move) begin
			pulse_n = pulse_q;
		end else if (nxt < signed'({2'b00, sft_pkg::PULSE_MIN})) begin
			pulse_n = sft_pkg::PULSE_MIN;
		end else if (nxt > signed'({2'b00, sft_pkg::PULSE_MAX})) begin
			pulse_n = sft_pkg::PULSE_MAX;
		end else begin
			pulse_n = nxt[11:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			now_s1   <= s_tdata[31:0];
			col_s1   <= s_tdata[41:32];
			found_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q      <= sft_pkg::PULSE_CENTRE;
			last_track_q <= '0;
			last_scan_q  <= '0;
			lost_q       <= '0;
			sweep_up_q   <= 1'b1;
		end else if (advance) begin
			pulse_q      <= pulse_n;
			last_track_q <= last_track_n;
			last_scan_q  <= last_scan_n;
			lost_q       <= lost_n;
			sweep_up_q   <= sweep_up_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_pulse_q  <= pulse_n;
			out_action_q <= act;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_pulse_q};
	assign m_tuser  = out_action_q;

	`SFT_ASSERT(a_pulse_range, clk, arst_n, pulse_q >= sft_pkg::PULSE_MIN && pulse_q <= sft_pkg::PULSE_MAX)
	`SFT_ASSERT_NEXT(a_skip_holds, clk, arst_n, advance && act == sft_pkg::ACT_RATE_SKIP, pulse_q == $past(pulse_q) && last_track_q == $past(last_track_q))
	`SFT_ASSERT_NEXT(a_face_clears_lost, clk, arst_n, advance && found_s1 && act != sft_pkg::ACT_RATE_SKIP, lost_q == '0)
	`SFT_ASSERT_NEXT(a_result_tracks_state, clk, arst_n, advance, m_tvalid && m_tdata[11:0] == pulse_q)
	`SFT_ASSERT_NEXT(a_stage_holds, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(now_s1))

endmodule
